/* rtl/ptc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation unit.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int FINE_OFFSET = 128000;
  localparam int RAW_FULL    = 1048576;
  localparam int PRESS_SCALE = 3125;
  localparam int DIV_BITS    = 64;
  localparam int FRONT_DEPTH = 8;
  localparam int BACK_DEPTH  = 5;

  typedef enum logic [1:0] {
    CFG_TEMP     = 2'd0,
    CFG_PRESS_LO = 2'd1,
    CFG_PRESS_HI = 2'd2,
    CFG_PRESS_P9 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeff_t;

  typedef struct packed {
    logic [63:0] mag_num;
    logic [30:0] mag_den;
    logic        neg;
    logic        den_zero;
    logic [15:0] temp;
  } div_in_t;

  typedef struct packed {
    logic [63:0] quo;
    logic        neg;
    logic        den_zero;
    logic [15:0] temp;
  } div_out_t;

  typedef struct packed {
    logic [15:0] temperature_centideg;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
  } result_t;

endpackage

/* rtl/ptc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_if
// Valid/ready channels: raw sample input, compensated result, config write.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] pressure_raw;
  logic [19:0] temperature_raw;
  modport source(output valid, pressure_raw, temperature_raw, input ready);
  modport sink(input valid, pressure_raw, temperature_raw, output ready);
endinterface

interface ptc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] temperature_centideg;
  logic [31:0] pressure_q24_8;
  logic        pressure_valid;
  modport source(output valid, temperature_centideg, pressure_q24_8, pressure_valid,
                 input ready);
  modport sink(input valid, temperature_centideg, pressure_q24_8, pressure_valid,
               output ready);
endinterface

interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/pressure_temperature_compensation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Integer compensation of raw pressure/temperature samples.
// ----------------------------------------------------------------------------
// Takes one item per clock while out is not stalled; each item passes 8 front
// stages (temperature and divisor prep), 64 divider stages at one quotient bit
// each, then 5 back stages; the divider is the longest section. When out is
// stalled the whole pipeline holds and in_ch.ready drops in the same cycle.
// Coefficients are read live from the config registers; write them only
// while no item is in flight.
module pressure_temperature_compensation_unit (
  input  logic          clk,
  input  logic          rst_n,
  ptc_in_if.sink        in_ch,
  ptc_out_if.source     out_ch,
  ptc_cfg_if.sink       cfg_ch
);

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [15:0] press_p9_r;

  ptc_pkg::coeff_t    coef;
  ptc_pkg::div_in_t   front_dout;
  ptc_pkg::div_out_t  div_dout;
  ptc_pkg::result_t   res;
  logic               en;
  logic               front_vld;
  logic               div_vld;
  logic               out_vld;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      press_p9_r    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (ptc_pkg::cfg_idx_t'(cfg_ch.index))
        ptc_pkg::CFG_TEMP:     temp_coeffs_r <= cfg_ch.data[47:0];
        ptc_pkg::CFG_PRESS_LO: press_lo_r    <= cfg_ch.data;
        ptc_pkg::CFG_PRESS_HI: press_hi_r    <= cfg_ch.data;
        ptc_pkg::CFG_PRESS_P9: press_p9_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign coef.t1 = temp_coeffs_r[15:0];
  assign coef.t2 = $signed(temp_coeffs_r[31:16]);
  assign coef.t3 = $signed(temp_coeffs_r[47:32]);
  assign coef.p1 = press_lo_r[15:0];
  assign coef.p2 = $signed(press_lo_r[31:16]);
  assign coef.p3 = $signed(press_lo_r[47:32]);
  assign coef.p4 = $signed(press_lo_r[63:48]);
  assign coef.p5 = $signed(press_hi_r[15:0]);
  assign coef.p6 = $signed(press_hi_r[31:16]);
  assign coef.p7 = $signed(press_hi_r[47:32]);
  assign coef.p8 = $signed(press_hi_r[63:48]);
  assign coef.p9 = $signed(press_p9_r);

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  ptc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .vld_in          (in_ch.valid),
    .pressure_raw    (in_ch.pressure_raw),
    .temperature_raw (in_ch.temperature_raw),
    .coef            (coef),
    .vld_out         (front_vld),
    .dout            (front_dout)
  );

  ptc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (front_vld),
    .din     (front_dout),
    .vld_out (div_vld),
    .dout    (div_dout)
  );

  ptc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (div_vld),
    .din     (div_dout),
    .coef    (coef),
    .vld_out (out_vld),
    .res     (res)
  );

  assign out_ch.valid                = out_vld;
  assign out_ch.temperature_centideg = $signed(res.temperature_centideg);
  assign out_ch.pressure_q24_8       = res.pressure_q24_8;
  assign out_ch.pressure_valid       = res.pressure_valid;

endmodule

/* rtl/ptc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_front
// Temperature compensation and pressure divisor/dividend preparation.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [19:0]          pressure_raw,
  input  logic [19:0]          temperature_raw,
  input  ptc_pkg::coeff_t      coef,
  output logic                 vld_out,
  output ptc_pkg::div_in_t     dout
);

  logic [ptc_pkg::FRONT_DEPTH-1:0] vld_r;

  // stage 1
  logic signed [18:0] d3;
  logic signed [17:0] d4;
  logic signed [34:0] m1_s1_r;
  logic signed [35:0] m2_s1_r;
  logic [19:0]        adcp_s1_r;
  // stage 2
  logic signed [39:0] tb;
  logic signed [25:0] fine_nxt;
  logic signed [25:0] fine_s2_r;
  logic [19:0]        adcp_s2_r;
  // stage 3
  logic signed [28:0] f5;
  logic signed [28:0] fr;
  logic signed [20:0] tw;
  logic [15:0]        temp_nxt;
  logic signed [26:0] a;
  logic [15:0]        temp_s3_r;
  logic signed [53:0] aa_s3_r;
  logic signed [42:0] ap5_s3_r;
  logic signed [42:0] ap2_s3_r;
  logic [19:0]        adcp_s3_r;
  // stage 4
  logic signed [69:0] b1_full;
  logic signed [69:0] d1_full;
  logic [63:0]        b1_s4_r;
  logic [63:0]        d1_s4_r;
  logic signed [42:0] ap5_s4_r;
  logic signed [42:0] ap2_s4_r;
  logic [15:0]        temp_s4_r;
  logic [19:0]        adcp_s4_r;
  // stage 5
  logic [63:0]        b_s5_r;
  logic [63:0]        dv0_s5_r;
  logic [15:0]        temp_s5_r;
  logic [19:0]        adcp_s5_r;
  // stage 6
  logic signed [80:0] dvm_full;
  logic [20:0]        praw;
  logic [63:0]        dvm_s6_r;
  logic [63:0]        num0_s6_r;
  logic [15:0]        temp_s6_r;
  // stage 7
  logic signed [76:0] num_full;
  logic [30:0]        den_s7_r;
  logic [63:0]        num_s7_r;
  logic [15:0]        temp_s7_r;
  // stage 8
  ptc_pkg::div_in_t   out_s8_r;

  assign d3 = $signed({2'b0, temperature_raw[19:3]}) - $signed({2'b0, coef.t1, 1'b0});
  assign d4 = $signed({2'b0, temperature_raw[19:4]}) - $signed({2'b0, coef.t1});

  assign tb       = $signed(m2_s1_r[35:12]) * coef.t3;
  assign fine_nxt = $signed({{2{m1_s1_r[34]}}, m1_s1_r[34:11]}) + $signed(tb[39:14]);

  assign f5 = $signed({fine_s2_r[25], fine_s2_r, 2'b0}) +
              $signed({{3{fine_s2_r[25]}}, fine_s2_r});
  assign fr = f5 + 29'sd128;
  assign tw = $signed(fr[28:8]);
  always_comb begin
    priority if (tw > 21'sd32767) begin
      temp_nxt = 16'h7fff;
    end else if (tw < -21'sd32768) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = tw[15:0];
    end
  end
  assign a = $signed({fine_s2_r[25], fine_s2_r}) - 27'(ptc_pkg::FINE_OFFSET);

  assign b1_full = aa_s3_r * coef.p6;
  assign d1_full = aa_s3_r * coef.p3;

  assign dvm_full = $signed(dv0_s5_r) * $signed({1'b0, coef.p1});
  assign praw     = 21'(ptc_pkg::RAW_FULL) - {1'b0, adcp_s5_r};

  assign num_full = $signed(num0_s6_r) * $signed(13'(ptc_pkg::PRESS_SCALE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ptc_pkg::FRONT_DEPTH-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s1_r   <= d3 * coef.t2;
      m2_s1_r   <= d4 * d4;
      adcp_s1_r <= pressure_raw;

      fine_s2_r <= fine_nxt;
      adcp_s2_r <= adcp_s1_r;

      temp_s3_r <= temp_nxt;
      aa_s3_r   <= a * a;
      ap5_s3_r  <= a * coef.p5;
      ap2_s3_r  <= a * coef.p2;
      adcp_s3_r <= adcp_s2_r;

      b1_s4_r   <= b1_full[63:0];
      d1_s4_r   <= d1_full[63:0];
      ap5_s4_r  <= ap5_s3_r;
      ap2_s4_r  <= ap2_s3_r;
      temp_s4_r <= temp_s3_r;
      adcp_s4_r <= adcp_s3_r;

      b_s5_r    <= b1_s4_r + ({{21{ap5_s4_r[42]}}, ap5_s4_r} << 17) +
                   ({{48{coef.p4[15]}}, coef.p4} << 35);
      dv0_s5_r  <= {{8{d1_s4_r[63]}}, d1_s4_r[63:8]} +
                   ({{21{ap2_s4_r[42]}}, ap2_s4_r} << 12) + (64'd1 << 47);
      temp_s5_r <= temp_s4_r;
      adcp_s5_r <= adcp_s4_r;

      dvm_s6_r  <= dvm_full[63:0];
      num0_s6_r <= {12'b0, praw, 31'b0} - b_s5_r;
      temp_s6_r <= temp_s5_r;

      den_s7_r  <= dvm_s6_r[63:33];
      num_s7_r  <= num_full[63:0];
      temp_s7_r <= temp_s6_r;

      out_s8_r.mag_num  <= num_s7_r[63] ? (64'd0 - num_s7_r) : num_s7_r;
      out_s8_r.mag_den  <= den_s7_r[30] ? (31'd0 - den_s7_r) : den_s7_r;
      out_s8_r.neg      <= num_s7_r[63] ^ den_s7_r[30];
      out_s8_r.den_zero <= (den_s7_r == 31'd0);
      out_s8_r.temp     <= temp_s7_r;
    end
  end

  assign vld_out = vld_r[ptc_pkg::FRONT_DEPTH-1];
  assign dout    = out_s8_r;

endmodule

/* rtl/ptc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  ptc_pkg::div_in_t  din,
  output logic              vld_out,
  output ptc_pkg::div_out_t dout
);

  localparam int N = ptc_pkg::DIV_BITS;

  typedef struct packed {
    logic        neg;
    logic        den_zero;
    logic [15:0] temp;
  } meta_t;

  logic [N-1:0] vld_r;
  logic [30:0]  rem_r   [N];
  logic [63:0]  sh_r    [N];
  logic [30:0]  den_r   [N];
  meta_t        meta_r  [N];
  logic [30:0]  rem_nxt [N];
  logic [63:0]  sh_nxt  [N];

  always_comb begin
    logic [30:0] rem_in;
    logic [63:0] sh_in;
    logic [30:0] den_in;
    logic [31:0] trial;
    for (int k = 0; k < N; k++) begin
      rem_in = (k == 0) ? 31'd0 : rem_r[(k == 0) ? 0 : k-1];
      sh_in  = (k == 0) ? din.mag_num : sh_r[(k == 0) ? 0 : k-1];
      den_in = (k == 0) ? din.mag_den : den_r[(k == 0) ? 0 : k-1];
      trial  = {rem_in, sh_in[63]};
      if (trial >= {1'b0, den_in}) begin
        rem_nxt[k] = 31'(trial - {1'b0, den_in});
        sh_nxt[k]  = {sh_in[62:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[30:0];
        sh_nxt[k]  = {sh_in[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        sh_r[k]  <= sh_nxt[k];
        if (k == 0) begin
          den_r[k]  <= din.mag_den;
          meta_r[k] <= '{neg: din.neg, den_zero: din.den_zero, temp: din.temp};
        end else begin
          den_r[k]  <= den_r[(k == 0) ? 0 : k-1];
          meta_r[k] <= meta_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign vld_out       = vld_r[N-1];
  assign dout.quo      = sh_r[N-1];
  assign dout.neg      = meta_r[N-1].neg;
  assign dout.den_zero = meta_r[N-1].den_zero;
  assign dout.temp     = meta_r[N-1].temp;

endmodule

/* rtl/ptc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_back
// Pressure correction terms after the divide, offset, range check.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  ptc_pkg::div_out_t din,
  input  ptc_pkg::coeff_t   coef,
  output logic              vld_out,
  output ptc_pkg::result_t  res
);

  typedef struct packed {
    logic        den_zero;
    logic [15:0] temp;
  } meta_t;

  logic [ptc_pkg::BACK_DEPTH-1:0] vld_r;

  logic [63:0]        p_b1_r;
  meta_t              meta_b1_r;

  logic signed [50:0] sh13;
  logic signed [66:0] m1_full;
  logic signed [79:0] pd_full;
  logic [63:0]        p_b2_r;
  logic [50:0]        sh13_b2_r;
  logic [63:0]        m1_b2_r;
  logic [63:0]        pd_b2_r;
  meta_t              meta_b2_r;

  logic [63:0]        y;
  logic [63:0]        pll_b3_r;
  logic [31:0]        plh_b3_r;
  logic [31:0]        phl_b3_r;
  logic [63:0]        p_b3_r;
  logic [63:0]        pd_b3_r;
  meta_t              meta_b3_r;

  logic [63:0]        c_full;
  logic [63:0]        sum_b4_r;
  meta_t              meta_b4_r;

  logic [63:0]        s;
  ptc_pkg::result_t   res_nxt;
  ptc_pkg::result_t   res_r;

  assign sh13    = $signed(p_b1_r[63:13]);
  assign m1_full = coef.p9 * sh13;
  assign pd_full = $signed(p_b1_r) * coef.p8;

  assign y = {{13{sh13_b2_r[50]}}, sh13_b2_r};

  assign c_full = pll_b3_r + {plh_b3_r + phl_b3_r, 32'b0};

  assign s = {{8{sum_b4_r[63]}}, sum_b4_r[63:8]} + ({{48{coef.p7[15]}}, coef.p7} << 4);

  always_comb begin
    res_nxt.temperature_centideg = meta_b4_r.temp;
    if (meta_b4_r.den_zero || s[63]) begin
      res_nxt.pressure_valid = 1'b0;
      res_nxt.pressure_q24_8 = 32'd0;
    end else begin
      res_nxt.pressure_valid = 1'b1;
      res_nxt.pressure_q24_8 = (s[63:32] != 32'd0) ? 32'hffff_ffff : s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ptc_pkg::BACK_DEPTH-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_b1_r    <= din.neg ? (64'd0 - din.quo) : din.quo;
      meta_b1_r <= '{den_zero: din.den_zero, temp: din.temp};

      p_b2_r    <= p_b1_r;
      sh13_b2_r <= sh13;
      m1_b2_r   <= m1_full[63:0];
      pd_b2_r   <= pd_full[63:0];
      meta_b2_r <= meta_b1_r;

      pll_b3_r  <= m1_b2_r[31:0] * y[31:0];
      plh_b3_r  <= 32'(m1_b2_r[31:0] * y[63:32]);
      phl_b3_r  <= 32'(m1_b2_r[63:32] * y[31:0]);
      p_b3_r    <= p_b2_r;
      pd_b3_r   <= pd_b2_r;
      meta_b3_r <= meta_b2_r;

      sum_b4_r  <= p_b3_r + {{25{c_full[63]}}, c_full[63:25]} +
                   {{19{pd_b3_r[63]}}, pd_b3_r[63:19]};
      meta_b4_r <= meta_b3_r;

      res_r     <= res_nxt;
    end
  end

  assign vld_out = vld_r[ptc_pkg::BACK_DEPTH-1];
  assign res     = res_r;

endmodule

/* rtl/ptc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pressure_q24_8,
  input logic        pressure_valid
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pressure_valid |-> pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready != (out_valid && !out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pressure_q24_8 (out_ch.pressure_q24_8),
  .pressure_valid (out_ch.pressure_valid)
);

/* dv/tb_pressure_temperature_compensation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation_unit
// Self-checking bench for the compensation unit. Coefficient sets are loaded
// while the unit is idle; raw samples stream in with random gaps and output
// stalls. Each result is checked against a 64-bit integer compensation model.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation_unit;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [19:0] praw;
    logic [19:0] traw;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   errors = 0;

  ptc_in_if  in_if();
  ptc_out_if out_if();
  ptc_cfg_if cfg_if();

  pressure_temperature_compensation_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  logic [47:0] temp_coef = '0;
  logic [63:0] press_lo  = '0;
  logic [63:0] press_hi  = '0;
  logic [15:0] press_p9  = '0;

  sample_t pending_samples[$];
  ptc_pkg::result_t expected_results[$];

  logic idle_en   = 1'b1;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   tx_gap    = 0;
  int   rx_gap    = 0;
  int   rx_hold   = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic ptc_pkg::result_t compensate(logic [19:0] praw, logic [19:0] traw);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d3, d4, fine, temp, a, b, dv, p, num, c, d;
    ptc_pkg::result_t r;
    t1 = longint'(temp_coef[15:0]);
    t2 = s16(temp_coef[31:16]);
    t3 = s16(temp_coef[47:32]);
    p1 = longint'(press_lo[15:0]);
    p2 = s16(press_lo[31:16]);
    p3 = s16(press_lo[47:32]);
    p4 = s16(press_lo[63:48]);
    p5 = s16(press_hi[15:0]);
    p6 = s16(press_hi[31:16]);
    p7 = s16(press_hi[47:32]);
    p8 = s16(press_hi[63:48]);
    p9 = s16(press_p9);
    d3 = longint'(traw >> 3) - 2 * t1;
    d4 = longint'(traw >> 4) - t1;
    fine = ((d3 * t2) >>> 11) + ((((d4 * d4) >>> 12) * t3) >>> 14);
    temp = (fine * 5 + 128) >>> 8;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    a = fine - ptc_pkg::FINE_OFFSET;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    dv = ((a * a * p3) >>> 8) + ((a * p2) << 12);
    dv = (((64'sd1 <<< 47) + dv) * p1) >>> 33;
    r.temperature_centideg = temp[15:0];
    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (dv != 0) begin
      p = ptc_pkg::RAW_FULL - longint'(praw);
      num = ((p << 31) - b) * ptc_pkg::PRESS_SCALE;
      if (num == 64'sh8000_0000_0000_0000 && dv == -1) p = num;
      else p = num / dv;
      c = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
      d = (p8 * p) >>> 19;
      p = ((p + c + d) >>> 8) + (p7 << 4);
      if (p >= 0) begin
        r.pressure_valid = 1'b1;
        r.pressure_q24_8 = (p > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
      end
    end
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pressure_raw <= '0;
      in_if.temperature_raw <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_results.push_back(compensate(in_if.pressure_raw, in_if.temperature_raw));
      if (!(in_if.valid && !in_if.ready)) begin
        if (tx_gap > 0) begin
          in_if.valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_samples.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.pressure_raw <= pending_samples[0].praw;
          in_if.temperature_raw <= pending_samples[0].traw;
          void'(pending_samples.pop_front());
          if (idle_en && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 6);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, longint got, longint exp);
    $display("mismatch %s: got %0h exp %0h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  // receiver
  always @(posedge clk) begin
    ptc_pkg::result_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_if.temperature_centideg !== e.temperature_centideg)
            report("temperature", out_if.temperature_centideg, e.temperature_centideg);
          if (out_if.pressure_q24_8 !== e.pressure_q24_8)
            report("pressure", out_if.pressure_q24_8, e.pressure_q24_8);
          if (out_if.pressure_valid !== e.pressure_valid)
            report("pressure_valid", out_if.pressure_valid, e.pressure_valid);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        rx_hold <= 400;
        out_if.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 6);
      end
    end
  end

  task automatic cfg_write(ptc_pkg::cfg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      ptc_pkg::CFG_TEMP:     temp_coef = data[47:0];
      ptc_pkg::CFG_PRESS_LO: press_lo = data;
      ptc_pkg::CFG_PRESS_HI: press_hi = data;
      default:               press_p9 = data[15:0];
    endcase
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                             logic [15:0] p9);
    cfg_write(ptc_pkg::CFG_TEMP, {16'h0, tc});
    cfg_write(ptc_pkg::CFG_PRESS_LO, lo);
    cfg_write(ptc_pkg::CFG_PRESS_HI, hi);
    cfg_write(ptc_pkg::CFG_PRESS_P9, {48'h0, p9});
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_if.valid && expected_results.size() == 0);
    repeat (90) @(posedge clk);
  endtask

  task automatic add_sample(logic [19:0] p, logic [19:0] t);
    sample_t s;
    s.praw = p;
    s.traw = t;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0)
        add_sample(20'($urandom_range(250000, 500000)),
                   20'($urandom_range(480000, 560000)));
      else
        add_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
    end
  endtask

  task automatic add_corners();
    add_sample(20'h00000, 20'h00000);
    add_sample(20'hFFFFF, 20'hFFFFF);
    add_sample(20'h00000, 20'hFFFFF);
    add_sample(20'hFFFFF, 20'h00000);
    add_sample(20'h55555, 20'hAAAAA);
    add_sample(20'hAAAAA, 20'h55555);
  endtask

  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_LO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_HI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = ptc_pkg::CFG_TEMP;
    cfg_if.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: zero divisor, pressure invalid
    add_corners();
    drain();

    load_coeffs(TYP_T, TYP_LO, TYP_HI, 16'd6000);
    add_corners();
    add_sample(20'd415148, 20'd519888);
    add_sample(20'd300000, 20'd500000);
    add_sample(20'd700000, 20'd519888);
    drain();
    // negative pressure and large P7 offsets
    load_coeffs(TYP_T, TYP_LO, {TYP_HI[63:48], 16'h8000, TYP_HI[31:0]}, 16'd6000);
    add_corners();
    add_sample(20'd415148, 20'd519888);
    drain();

    load_coeffs(TYP_T, TYP_LO, TYP_HI, 16'd6000);
    hold_req = 1'b1;
    add_random(650);
    drain();

    load_coeffs('1, '1, '1, '1);
    add_corners();
    add_random(100);
    drain();
    load_coeffs({16'h8000, 16'h7FFF, 16'hFFFF}, {4{16'h8000}}, {4{16'h7FFF}}, 16'h8000);
    add_corners();
    add_random(100);
    drain();
    load_coeffs({16'h7FFF, 16'h8000, 16'h0000}, {{3{16'h7FFF}}, 16'hFFFF},
                {4{16'h8000}}, 16'h7FFF);
    add_random(80);
    drain();
    for (int k = 0; k < 4; k++) begin
      load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      add_random(100);
      drain();
    end

    idle_en = 1'b0;
    load_coeffs(TYP_T, TYP_LO, TYP_HI, 16'($urandom));
    add_random(200);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
